// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the checker files of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
    else $error(msg);

// Checks that an expression is never true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
    else $error(msg);

`endif

// ===== hw/rtl/tws_pkg.sv =====
// Types, constants and helper functions of the time window switch timer.
package tws_pkg;

  localparam int unsigned NumPrograms = 16;
  localparam int unsigned ProgIdxW    = (NumPrograms > 1) ? $clog2(NumPrograms) : 1;
  localparam int unsigned DriveW      = 16;
  localparam int unsigned HourW       = 5;
  localparam int unsigned MinuteW     = 6;
  // Minutes since midnight, also for out-of-range times up to 31:63.
  localparam int unsigned TimeW       = 11;

  localparam logic [HourW-1:0]   HourMax   = HourW'(23);
  localparam logic [MinuteW-1:0] MinuteMax = MinuteW'(59);

  localparam logic [7:0] FieldStartHour   = 8'd1;
  localparam logic [7:0] FieldStartMinute = 8'd2;
  localparam logic [7:0] FieldStopHour    = 8'd3;
  localparam logic [7:0] FieldStopMinute  = 8'd4;

  typedef enum logic {
    CmdAdjust   = 1'b0,
    CmdEvaluate = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e                command;
    logic [7:0]          program_number;
    logic [7:0]          field_select;
    logic signed [7:0]   step;
    logic [HourW-1:0]    hour_of_day;
    logic [MinuteW-1:0]  minute_of_hour;
  } tws_in_t;

  typedef struct packed {
    logic [MinuteW-1:0] field_value;
    logic [DriveW-1:0]  drive_bits;
  } tws_out_t;

  // hour * 60 + minute, with the multiply done as two shifts.
  function automatic logic [TimeW-1:0] to_minutes(logic [HourW-1:0]   hour,
                                                  logic [MinuteW-1:0] minute);
    logic [TimeW-1:0] h64;
    logic [TimeW-1:0] h4;
    h64 = TimeW'({hour, 6'b000000});
    h4  = TimeW'({hour, 2'b00});
    return h64 - h4 + TimeW'(minute);
  endfunction

endpackage

// ===== hw/rtl/tws_eval.sv =====
// Parallel start/stop window compare for all programs.
module tws_eval import tws_pkg::*; (
  input  logic [HourW-1:0]       start_hour_i   [NumPrograms],
  input  logic [MinuteW-1:0]     start_minute_i [NumPrograms],
  input  logic [HourW-1:0]       stop_hour_i    [NumPrograms],
  input  logic [MinuteW-1:0]     stop_minute_i  [NumPrograms],
  input  logic [HourW-1:0]       hour_i,
  input  logic [MinuteW-1:0]     minute_i,
  output logic [NumPrograms-1:0] active_o
);

  logic [TimeW-1:0] now;

  assign now = to_minutes(hour_i, minute_i);

  always_comb begin
    logic [TimeW-1:0] start_t;
    logic [TimeW-1:0] stop_t;
    active_o = '0;
    for (int i = 0; i < NumPrograms; i++) begin
      start_t     = to_minutes(start_hour_i[i], start_minute_i[i]);
      stop_t      = to_minutes(stop_hour_i[i], stop_minute_i[i]);
      active_o[i] = (start_t <= now) && (now < stop_t);
    end
  end

endmodule

// ===== hw/rtl/time_window_switch_timer.sv =====
// Top level of the time window switch timer: program table, adjust and evaluate.
//
// The block holds a table of switching programs, each with a start and a stop
// time of day, all cleared to zero at reset. An adjust beat (command 0) adds a
// signed step to one field of one program (1 start hour, 2 start minute,
// 3 stop hour, 4 stop minute); a sum below zero wraps to the field maximum and
// a sum above it wraps to zero. The result beat carries the new field value
// and an all-ones drive word. An unknown program or field changes nothing and
// returns a value of zero. An evaluate beat (command 1) gives the time of day,
// and the result carries an active-low drive word in which bit i is low when
// program i+1 satisfies start <= now < stop; times are compared as
// hour*60+minute without range checks. Throughput is one beat per cycle while
// results are taken as they come. An input register and a result register
// frame the logic, in which the table read-modify-write and the sixteen window
// compares are done. A table update lands at the same edge its result is
// registered, so the next beat always sees it. The input stalls only while a
// result waits to be taken.
module time_window_switch_timer import tws_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  tws_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output tws_out_t out_data_o
);

  // Input register.
  logic    in_valid_q;
  tws_in_t in_q;

  // Result register.
  logic     out_valid_q;
  tws_out_t out_q;
  tws_out_t out_d;

  // Program table.
  logic [HourW-1:0]   start_hour_q   [NumPrograms];
  logic [MinuteW-1:0] start_minute_q [NumPrograms];
  logic [HourW-1:0]   stop_hour_q    [NumPrograms];
  logic [MinuteW-1:0] stop_minute_q  [NumPrograms];

  logic                  advance;
  logic                  prog_ok;
  logic                  field_ok;
  logic [7:0]            prog_m1;
  logic [ProgIdxW-1:0]   prog_idx;
  logic [MinuteW-1:0]    cur_value;
  logic [MinuteW-1:0]    max_value;
  logic signed [8:0]     sum;
  logic [MinuteW-1:0]    new_value;
  logic                  table_we;
  logic [NumPrograms-1:0] active;

  // The beat in the input register moves to the result register whenever
  // the result register is empty or is being emptied in this cycle.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // Program numbers are 1-based on the interface.
  assign prog_ok  = (in_q.program_number != 8'd0) &&
                    (in_q.program_number <= 8'(NumPrograms));
  assign prog_m1  = in_q.program_number - 8'd1;
  assign prog_idx = prog_m1[ProgIdxW-1:0];

  // Pick the addressed field and its upper bound.
  always_comb begin
    field_ok  = 1'b1;
    cur_value = '0;
    max_value = MinuteMax;
    unique case (in_q.field_select)
      FieldStartHour: begin
        cur_value = MinuteW'(start_hour_q[prog_idx]);
        max_value = MinuteW'(HourMax);
      end
      FieldStartMinute: begin
        cur_value = start_minute_q[prog_idx];
      end
      FieldStopHour: begin
        cur_value = MinuteW'(stop_hour_q[prog_idx]);
        max_value = MinuteW'(HourMax);
      end
      FieldStopMinute: begin
        cur_value = stop_minute_q[prog_idx];
      end
      default: begin
        field_ok = 1'b0;
      end
    endcase
  end

  // Full-precision sum, then wrap at either end of the field's range.
  assign sum = $signed({3'b000, cur_value}) + $signed({in_q.step[7], in_q.step});

  always_comb begin
    if (sum < 9'sd0) begin
      new_value = max_value;
    end else if (sum > $signed({3'b000, max_value})) begin
      new_value = '0;
    end else begin
      new_value = sum[MinuteW-1:0];
    end
  end

  assign table_we = advance && (in_q.command == CmdAdjust) && prog_ok && field_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumPrograms; i++) begin
        start_hour_q[i]   <= '0;
        start_minute_q[i] <= '0;
        stop_hour_q[i]    <= '0;
        stop_minute_q[i]  <= '0;
      end
    end else if (table_we) begin
      unique case (in_q.field_select)
        FieldStartHour:   start_hour_q[prog_idx]   <= new_value[HourW-1:0];
        FieldStartMinute: start_minute_q[prog_idx] <= new_value;
        FieldStopHour:    stop_hour_q[prog_idx]    <= new_value[HourW-1:0];
        FieldStopMinute:  stop_minute_q[prog_idx]  <= new_value;
        default: ;
      endcase
    end
  end

  tws_eval u_tws_eval (
    .start_hour_i   (start_hour_q),
    .start_minute_i (start_minute_q),
    .stop_hour_i    (stop_hour_q),
    .stop_minute_i  (stop_minute_q),
    .hour_i         (in_q.hour_of_day),
    .minute_i       (in_q.minute_of_hour),
    .active_o       (active)
  );

  // Result assembly. Drive bits of programs that do not exist stay high.
  always_comb begin
    out_d.field_value = '0;
    out_d.drive_bits  = '1;
    unique case (in_q.command)
      CmdAdjust: begin
        if (prog_ok && field_ok) begin
          out_d.field_value = new_value;
        end
      end
      CmdEvaluate: begin
        out_d.drive_bits[NumPrograms-1:0] = ~active;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/tws_checker.sv =====
// Port-level checker for the time window switch timer, with its bind.
`include "assert_macros.svh"

module tws_checker import tws_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input tws_out_t out_data_o
);

  logic     in_fire;
  logic     out_stall;
  logic     eval_shape;
  logic     adjust_shape;
  logic     value_high;
  logic     held;
  tws_out_t out_data_q;

  assign in_fire      = in_valid_i && in_ready_o;
  assign out_stall    = out_valid_o && !out_ready_i;
  assign eval_shape   = (out_data_o.field_value == '0);
  assign adjust_shape = (out_data_o.drive_bits == '1);
  assign value_high   = (out_data_o.field_value > MinuteMax);

  // Registered copy of the result payload, so a held beat can be compared with itself.
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_o;
  end

  assign held = out_valid_o && (out_data_o == out_data_q);

  // The input only stalls behind a result that is waiting to be taken.
  `ASSERT_PROP(a_stall, clk_i, rst_ni, !in_ready_o |-> out_stall, "input stall with no held result")

  // A beat is either an adjust result or an evaluate result, never a mix.
  `ASSERT_PROP(a_kind, clk_i, rst_ni, out_valid_o |-> (eval_shape || adjust_shape), "mixed result")

  // Field values never leave the minute range.
  `ASSERT_NEVER(a_value_range, clk_i, rst_ni, out_valid_o && value_high, "field value above range")

  // An accepted beat with no result waiting reaches the output through the input and result registers.
  `ASSERT_PROP(a_latency, clk_i, rst_ni, (in_fire && !out_valid_o) |-> ##2 out_valid_o, "lost beat")

  // A stalled result holds.
  `ASSERT_PROP(a_out_hold, clk_i, rst_ni, out_stall |=> held, "stalled result changed")

endmodule

bind time_window_switch_timer tws_checker u_tws_checker (.*);

// ===== dv/tws_check_pkg.sv =====
// Program table predictor and reply checker for the time window switch timer bench.
package tws_check_pkg;
  import tws_pkg::*;

  class program_table_checker;
    logic [HourW-1:0]   start_hr  [NumPrograms];
    logic [MinuteW-1:0] start_min [NumPrograms];
    logic [HourW-1:0]   stop_hr   [NumPrograms];
    logic [MinuteW-1:0] stop_min  [NumPrograms];

    tws_out_t owed_replies[$];

    int mismatches;
    int adjusts;
    int evaluates;
    int replies_checked;

    function new();
      for (int i = 0; i < NumPrograms; i++) begin
        start_hr[i]  = '0;
        start_min[i] = '0;
        stop_hr[i]   = '0;
        stop_min[i]  = '0;
      end
    endfunction

    // Full-precision add; underflow lands on the field maximum, overflow on zero.
    static function int bump_field(int cur, logic signed [7:0] delta, int top);
      int sum;
      sum = cur + int'(delta);
      if (sum < 0) return top;
      if (sum > top) return 0;
      return sum;
    endfunction

    function void note_beat(tws_in_t beat);
      tws_out_t           want;
      int                 idx;
      int                 now;
      int                 t_on;
      int                 t_off;
      logic [DriveW-1:0]  lit;
      if (beat.command == CmdAdjust) begin
        adjusts++;
        want.field_value = '0;
        want.drive_bits  = '1;
        if (beat.program_number >= 1 && beat.program_number <= NumPrograms) begin
          idx = int'(beat.program_number) - 1;
          case (beat.field_select)
            FieldStartHour: begin
              start_hr[idx] = HourW'(bump_field(start_hr[idx], beat.step, HourMax));
              want.field_value = MinuteW'(start_hr[idx]);
            end
            FieldStartMinute: begin
              start_min[idx] = MinuteW'(bump_field(start_min[idx], beat.step, MinuteMax));
              want.field_value = start_min[idx];
            end
            FieldStopHour: begin
              stop_hr[idx] = HourW'(bump_field(stop_hr[idx], beat.step, HourMax));
              want.field_value = MinuteW'(stop_hr[idx]);
            end
            FieldStopMinute: begin
              stop_min[idx] = MinuteW'(bump_field(stop_min[idx], beat.step, MinuteMax));
              want.field_value = stop_min[idx];
            end
            default: ;
          endcase
        end
      end else begin
        evaluates++;
        now = int'(beat.hour_of_day) * 60 + int'(beat.minute_of_hour);
        lit = '0;
        for (int i = 0; i < NumPrograms; i++) begin
          t_on  = int'(start_hr[i]) * 60 + int'(start_min[i]);
          t_off = int'(stop_hr[i]) * 60 + int'(stop_min[i]);
          lit[i] = (t_on <= now) && (now < t_off);
        end
        want.field_value = '0;
        want.drive_bits  = ~lit;
      end
      owed_replies.push_back(want);
    endfunction

    task report(string what);
      mismatches++;
      $display("ERROR at %0t: %s", $time, what);
    endtask

    task check_reply(tws_out_t got);
      tws_out_t want;
      if (owed_replies.size() == 0) begin
        report($sformatf("unexpected reply: field_value %0d drive_bits %h",
                         got.field_value, got.drive_bits));
      end else begin
        want = owed_replies.pop_front();
        replies_checked++;
        if (got.field_value !== want.field_value)
          report($sformatf("reply %0d field_value %0d, want %0d", replies_checked,
                           got.field_value, want.field_value));
        if (got.drive_bits !== want.drive_bits)
          report($sformatf("reply %0d drive_bits %h, want %h", replies_checked,
                           got.drive_bits, want.drive_bits));
      end
    endtask
  endclass

endpackage

// ===== dv/tb_top.sv =====
// Self-checking bench for the time window switch timer: directed and random beats.
module tb_top;
  import tws_pkg::*;
  import tws_check_pkg::*;

  // A run with no handshake for this many cycles is considered hung. The worst
  // honest gap is a full sender idle plus a full receiver stall plus the two
  // pipeline stages.
  localparam int HangLimit   = 400;
  // Cycles to watch for stray replies once nothing is owed any more.
  localparam int SettleTime  = 20;
  localparam int RandomBeats = 100;  // per phase, four phases
  localparam int MaxIdle     = 17;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  tws_in_t  in_data   = '0;
  logic     out_ready = 1'b0;
  logic     in_ready;
  logic     out_valid;
  tws_out_t out_data;

  // Idling switches, changed per phase so that both-idle, one-side-idle and
  // no-idle stretches all occur.
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;

  program_table_checker chk = new();

  time_window_switch_timer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Every handshake is seen here at the edge where it completes. The bench
  // drives with nonblocking assignments and the block registers its result outputs,
  // so all values read here are the ones from before the edge. Inputs are
  // noted before replies are checked, which keeps the order right even if a
  // reply could come back at the edge its beat was taken.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) chk.note_beat(in_data);
    if (rst_n && out_valid && out_ready) chk.check_reply(out_data);
  end

  // Presents one beat after a random idle time. With no idle time the valid
  // stays high from the previous beat and only the payload changes.
  task automatic send_beat(tws_in_t beat);
    int gap;
    gap = send_idle ? $urandom_range(0, MaxIdle) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
  endtask

  // Holds the sender off until every reply owed has come back. The first
  // edge is always waited out, so the monitor has seen the last beat.
  task automatic drain_replies();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chk.owed_replies.size() != 0) @(posedge clk);
  endtask

  function automatic tws_in_t adjust_beat(int prog, int field, int delta);
    tws_in_t b;
    b = '0;
    b.command        = CmdAdjust;
    b.program_number = 8'(prog);
    b.field_select   = 8'(field);
    b.step           = 8'(delta);
    return b;
  endfunction

  function automatic tws_in_t evaluate_beat(int hour, int minute);
    tws_in_t b;
    b = '0;
    b.command        = CmdEvaluate;
    b.hour_of_day    = HourW'(hour);
    b.minute_of_hour = MinuteW'(minute);
    return b;
  endfunction

  // Random beats. Most are well-formed adjusts and evaluates with random
  // content; the unused fields of each stay random. One beat in ten is pure
  // noise, which reaches bad program numbers, bad field codes and times
  // past 23:59.
  function automatic tws_in_t random_beat();
    tws_in_t    b;
    logic [63:0] raw;
    int          pick;
    raw  = {$urandom, $urandom};
    b    = tws_in_t'(raw[$bits(tws_in_t)-1:0]);
    pick = $urandom_range(0, 9);
    if (pick >= 1 && pick <= 5) begin
      b.command        = CmdAdjust;
      b.program_number = 8'($urandom_range(1, NumPrograms));
      case ($urandom_range(0, 3))
        0:       b.field_select = FieldStartHour;
        1:       b.field_select = FieldStartMinute;
        2:       b.field_select = FieldStopHour;
        default: b.field_select = FieldStopMinute;
      endcase
      // Small steps walk windows around; full-range steps force the wraps.
      if ($urandom_range(0, 1) == 0) b.step = 8'(int'($urandom_range(0, 12)) - 6);
    end else if (pick >= 6) begin
      b.command = CmdEvaluate;
      if ($urandom_range(0, 7) != 0) begin
        b.hour_of_day    = HourW'($urandom_range(0, 23));
        b.minute_of_hour = MinuteW'($urandom_range(0, 59));
      end
    end
    return b;
  endfunction

  // The receiver takes replies with a random stall in front of each one.
  initial begin
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = recv_idle ? $urandom_range(0, MaxIdle) : 0;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Hang detection: any cycle without a handshake on either side counts.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < HangLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("hung for %0d cycles with %0d replies owed", HangLimit,
             chk.owed_replies.size());
    $display("time_window_switch_timer: mismatch");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Freshly cleared table: every window is empty, so nothing drives, even
    // at the latest time the fields can carry.
    send_beat(evaluate_beat(0, 0));
    send_beat(evaluate_beat(31, 63));
    // Adjusts that must change nothing: program zero, program past the table,
    // both codes all ones, and field codes on either side of the valid set.
    send_beat(adjust_beat(0, FieldStartHour, 5));
    send_beat(adjust_beat(NumPrograms + 1, FieldStartHour, 5));
    send_beat(adjust_beat(255, 255, -128));
    send_beat(adjust_beat(1, 0, 1));
    send_beat(adjust_beat(1, 5, 1));
    // Wraps: below zero lands on the maximum, past the maximum lands on zero.
    send_beat(adjust_beat(1, FieldStartHour, -1));
    send_beat(adjust_beat(1, FieldStartHour, 1));
    send_beat(adjust_beat(1, FieldStartHour, 8));
    send_beat(adjust_beat(1, FieldStartMinute, -128));
    send_beat(adjust_beat(1, FieldStartMinute, -29));
    send_beat(adjust_beat(1, FieldStopHour, 127));
    send_beat(adjust_beat(1, FieldStopHour, 17));
    send_beat(adjust_beat(1, FieldStopMinute, 15));
    // Program 1 now runs 08:30 to 17:15; probe both edges of the window.
    send_beat(evaluate_beat(8, 29));
    send_beat(evaluate_beat(8, 30));
    send_beat(evaluate_beat(17, 14));
    send_beat(evaluate_beat(17, 15));
    // The last program spans 00:00 to 23:59, reached with exact maxima.
    send_beat(adjust_beat(NumPrograms, FieldStopHour, 23));
    send_beat(adjust_beat(NumPrograms, FieldStopMinute, 59));
    send_beat(evaluate_beat(23, 58));
    // A reversed window (20:00 to 00:00) never drives.
    send_beat(adjust_beat(2, FieldStartHour, 20));
    send_beat(evaluate_beat(20, 0));
    // An hour past the day is compared as given and falls outside every window.
    send_beat(evaluate_beat(24, 0));
    drain_replies();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle = (phase == 0) || (phase == 2);
      recv_idle = (phase == 0) || (phase == 3);
      repeat (RandomBeats) send_beat(random_beat());
      drain_replies();
    end

    // Nothing owed any more; watch a little longer for stray replies.
    repeat (SettleTime) @(posedge clk);
    if (chk.owed_replies.size() != 0)
      chk.report($sformatf("%0d replies never arrived", chk.owed_replies.size()));

    $display("Covered %0d adjust and %0d evaluate beats, %0d replies compared.",
             chk.adjusts, chk.evaluates, chk.replies_checked);
    $display("Idling ran on both sides, on each side alone and on neither; %0d errors.",
             chk.mismatches);
    if (chk.mismatches == 0) begin
      $display("time_window_switch_timer: match");
    end else begin
      $display("time_window_switch_timer: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/tws_pkg.sv
hw/rtl/tws_eval.sv
hw/rtl/time_window_switch_timer.sv
hw/rtl/tws_checker.sv
dv/tws_check_pkg.sv
dv/tb_top.sv
